FILE: sv/mffd_pkg.sv
// Shared types, constants and helpers for the micromouse flood fill block.
package mffd_pkg;

  // Grid geometry: 16 columns (x) of 16 rows (y).
  localparam int unsigned GridSize = 16;
  localparam int unsigned CoordW   = 4;
  localparam int unsigned DistW    = 9;
  localparam int unsigned WallW    = 4;

  // Wall bit positions inside a cell's wall word.
  localparam int unsigned WallN = 0;
  localparam int unsigned WallE = 1;
  localparam int unsigned WallS = 2;
  localparam int unsigned WallW_BIT = 3;

  // Command codes.
  localparam logic [1:0] MODE_WALLS = 2'd0;
  localparam logic [1:0] MODE_FILL  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // The four goal cells sit at x and y in {7, 8}.
  localparam logic [CoordW-1:0] GoalLo = 4'd7;
  localparam logic [CoordW-1:0] GoalHi = 4'd8;

  // Distance given to the goal cells and the level of the first wavefront step.
  localparam logic [DistW-1:0] GoalDist  = 9'd1;
  localparam logic [DistW-1:0] FirstStep = 9'd2;

  // Control word broadcast from the sequencer to every column cell.
  typedef struct packed {
    logic              wr_en;
    logic [CoordW-1:0] wr_col;
    logic [CoordW-1:0] row;
    logic [WallW-1:0]  walls;
    logic              seed;
    logic              step;
    logic [DistW-1:0]  level;
  } mffd_ctrl_t;

  // True for the four centre goal cells.
  function automatic logic is_goal(logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    is_goal = ((x == GoalLo) || (x == GoalHi)) && ((y == GoalLo) || (y == GoalHi));
  endfunction

endpackage

FILE: sv/mffd_column.sv
// One column cell of the flood fill array: walls, distances and frontier of 16 cells.
module mffd_column (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [mffd_pkg::CoordW-1:0]            col_i,
  input  mffd_pkg::mffd_ctrl_t                   ctrl_i,
  input  logic [mffd_pkg::GridSize-1:0]          east_i,
  input  logic [mffd_pkg::GridSize-1:0]          west_i,
  output logic [mffd_pkg::GridSize-1:0]          east_o,
  output logic [mffd_pkg::GridSize-1:0]          west_o,
  output logic                                   active_o,
  output logic [mffd_pkg::DistW-1:0]             rd_dist_o
);

  logic [mffd_pkg::WallW-1:0] walls_q [mffd_pkg::GridSize];
  logic [mffd_pkg::DistW-1:0] dist_q  [mffd_pkg::GridSize];
  logic [mffd_pkg::GridSize-1:0] front_q;
  logic [mffd_pkg::GridSize-1:0] reach;
  logic                          wall_we;

  assign wall_we = ctrl_i.wr_en && (ctrl_i.wr_col == col_i);

  // Frontier cells that may move sideways are handed to the neighbor columns.
  // Per row: arrivals from below, above and the side columns reach unvisited cells.
  for (genvar g = 0; g < mffd_pkg::GridSize; g++) begin : g_row
    logic from_south;
    logic from_north;

    assign east_o[g] = front_q[g] & ~walls_q[g][mffd_pkg::WallE];
    assign west_o[g] = front_q[g] & ~walls_q[g][mffd_pkg::WallW_BIT];

    if (g > 0) begin : g_s
      assign from_south = front_q[g-1] & ~walls_q[g-1][mffd_pkg::WallN];
    end else begin : g_s_edge
      assign from_south = 1'b0;
    end

    if (g < mffd_pkg::GridSize - 1) begin : g_n
      assign from_north = front_q[g+1] & ~walls_q[g+1][mffd_pkg::WallS];
    end else begin : g_n_edge
      assign from_north = 1'b0;
    end

    assign reach[g] = (from_south | from_north | east_i[g] | west_i[g]) &&
                      (dist_q[g] == '0);
  end

  assign active_o  = |front_q;
  assign rd_dist_o = dist_q[ctrl_i.row];

  // Wall words are written one cell at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int y = 0; y < mffd_pkg::GridSize; y++) begin
        walls_q[y] <= '0;
      end
    end else if (wall_we) begin
      walls_q[ctrl_i.row] <= ctrl_i.walls;
    end
  end

  // Seeding clears the column and marks the goals; each step advances the wavefront.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      for (int y = 0; y < mffd_pkg::GridSize; y++) begin
        dist_q[y] <= '0;
      end
    end else if (ctrl_i.seed) begin
      for (int y = 0; y < mffd_pkg::GridSize; y++) begin
        if (mffd_pkg::is_goal(col_i, mffd_pkg::CoordW'(y))) begin
          dist_q[y]  <= mffd_pkg::GoalDist;
          front_q[y] <= 1'b1;
        end else begin
          dist_q[y]  <= '0;
          front_q[y] <= 1'b0;
        end
      end
    end else if (ctrl_i.step) begin
      front_q <= reach;
      for (int y = 0; y < mffd_pkg::GridSize; y++) begin
        if (reach[y]) begin
          dist_q[y] <= ctrl_i.level;
        end
      end
    end
  end

endmodule

FILE: sv/maze_flood_fill_distance_top.sv
// Top level of the micromouse flood fill block: command sequencer and column chain.
//
// Commands are taken at a rising edge where start is high and busy is low.
// Mode 0 writes the wall word of cell_index_i; it gives no result and busy
// stays low, so a new command may follow in the next cycle.
// Mode 2 reads the distance of cell_index_i; the result word appears in the
// cycle after the command, with fill_done_o low, and busy stays low.
// Mode 1 runs a flood fill: the seed is done at the command edge, then the
// wavefront advances one level per cycle through a row of 16 column cells,
// each holding 16 cells and handing sideways moves to its neighbors. When no
// frontier remains, the distance of cell 0 comes out with fill_done_o high.
// Busy is high from the command until the result word appears.
// Mode 3 is ignored. Each result word is shown for one cycle, marked by
// result_valid_o; the receiver cannot stall it.
// Reset clears all walls, distances and the sequencer at once.
module maze_flood_fill_distance_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     mode_i,
  input  logic [7:0]                     cell_index_i,
  input  logic [mffd_pkg::WallW-1:0]     wall_bits_i,
  output logic                           result_valid_o,
  output logic [7:0]                     result_cell_o,
  output logic [mffd_pkg::DistW-1:0]     distance_o,
  output logic                           fill_done_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                            state_q;
  logic [mffd_pkg::DistW-1:0]        level_q;
  logic                              valid_q;
  logic [7:0]                        cell_q;
  logic [mffd_pkg::DistW-1:0]        dist_q;
  logic                              done_q;

  logic                              accept;
  logic                              any_active;
  logic [mffd_pkg::CoordW-1:0]       rd_col;
  logic [mffd_pkg::DistW-1:0]        rd_sel;
  mffd_pkg::mffd_ctrl_t              ctrl;

  logic [mffd_pkg::GridSize-1:0]     east_w   [mffd_pkg::GridSize];
  logic [mffd_pkg::GridSize-1:0]     west_w   [mffd_pkg::GridSize];
  logic [mffd_pkg::DistW-1:0]        rd_dist  [mffd_pkg::GridSize];
  logic [mffd_pkg::GridSize-1:0]     active_w;

  assign accept     = start && (state_q == ST_IDLE);
  assign busy       = (state_q == ST_RUN);
  assign any_active = |active_w;

  // While filling, the read port points at the start cell.
  assign rd_col = busy ? '0 : cell_index_i[7:4];

  // Control word for the column chain.
  always_comb begin
    ctrl        = '0;
    ctrl.wr_en  = accept && (mode_i == mffd_pkg::MODE_WALLS);
    ctrl.wr_col = cell_index_i[7:4];
    ctrl.row    = busy ? '0 : cell_index_i[3:0];
    ctrl.walls  = wall_bits_i;
    ctrl.seed   = accept && (mode_i == mffd_pkg::MODE_FILL);
    ctrl.step   = busy && any_active;
    ctrl.level  = level_q;
  end

  // Column chain; moves off the grid at either end are dropped.
  for (genvar g = 0; g < mffd_pkg::GridSize; g++) begin : g_col
    logic [mffd_pkg::GridSize-1:0] east_in;
    logic [mffd_pkg::GridSize-1:0] west_in;

    if (g > 0) begin : g_w
      assign east_in = east_w[g-1];
    end else begin : g_w_edge
      assign east_in = '0;
    end

    if (g < mffd_pkg::GridSize - 1) begin : g_e
      assign west_in = west_w[g+1];
    end else begin : g_e_edge
      assign west_in = '0;
    end

    mffd_column u_column (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .col_i     (mffd_pkg::CoordW'(g)),
      .ctrl_i    (ctrl),
      .east_i    (east_in),
      .west_i    (west_in),
      .east_o    (east_w[g]),
      .west_o    (west_w[g]),
      .active_o  (active_w[g]),
      .rd_dist_o (rd_dist[g])
    );
  end

  assign rd_sel = rd_dist[rd_col];

  // Sequencer state and the registered result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      level_q <= mffd_pkg::FirstStep;
      valid_q <= 1'b0;
      cell_q  <= '0;
      dist_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (mode_i)
              mffd_pkg::MODE_FILL: begin
                state_q <= ST_RUN;
                level_q <= mffd_pkg::FirstStep;
              end
              mffd_pkg::MODE_READ: begin
                valid_q <= 1'b1;
                cell_q  <= cell_index_i;
                dist_q  <= rd_sel;
                done_q  <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          if (any_active) begin
            level_q <= level_q + 1'b1;
          end else begin
            valid_q <= 1'b1;
            cell_q  <= '0;
            dist_q  <= rd_sel;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = valid_q;
  assign result_cell_o  = cell_q;
  assign distance_o     = dist_q;
  assign fill_done_o    = done_q;

endmodule
